FILE: hw/rtl/bum_pkg.sv
package bum_pkg;

   // field widths
   localparam int unsigned AdcWidth   = 12;
   localparam int unsigned GainWidth  = 20;
   localparam int unsigned MvWidth    = 16;
   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned LevelWidth = 24;   // millivolts, 8 fraction bits
   localparam int unsigned FracBits   = 8;
   localparam int unsigned ProdWidth  = AdcWidth + GainWidth;

   // stream packing
   localparam int unsigned ReqDataWidth = 48;
   localparam int unsigned RspDataWidth = 24;

   // register file
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   typedef enum logic [1:0] {
      REG_DIVIDER_GAIN   = 2'd0,
      REG_DISCONNECT_MV  = 2'd1,
      REG_CUTOFF_MV      = 2'd2,
      REG_SAG_TIMEOUT_MS = 2'd3
   } reg_index_type;

   typedef enum logic {
      FUNC_PRIME  = 1'b0,
      FUNC_UPDATE = 1'b1
   } func_type;

   localparam logic [GainWidth-1:0]  GainReset       = GainWidth'(105626);
   localparam logic [MvWidth-1:0]    DisconnectReset = MvWidth'(3000);
   localparam logic [MvWidth-1:0]    CutoffReset     = MvWidth'(6600);
   localparam logic [TimeWidth-1:0]  TimeoutReset    = TimeWidth'(2000);
   localparam logic [LevelWidth-1:0] LevelReset      = LevelWidth'(7000 * 256);

   typedef struct packed {
      logic [GainWidth-1:0] divider_gain;
      logic [MvWidth-1:0]   disconnect_mv;
      logic [MvWidth-1:0]   cutoff_mv;
      logic [TimeWidth-1:0] sag_timeout_ms;
   } cfg_type;

   // scaled sample handed from the scaling stage to the filter
   typedef struct packed {
      func_type              func;
      logic [LevelWidth-1:0] cur;
      logic [TimeWidth-1:0]  now_ms;
   } scaled_type;

endpackage

FILE: hw/rtl/bum_csr.sv
module bum_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bum_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [bum_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [bum_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                             csr_pready,
   output bum_pkg::cfg_type                 cfg
);
   import bum_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_DIVIDER_GAIN:   cfg_in.divider_gain   = csr_pwdata[GainWidth-1:0];
            REG_DISCONNECT_MV:  cfg_in.disconnect_mv  = csr_pwdata[MvWidth-1:0];
            REG_CUTOFF_MV:      cfg_in.cutoff_mv      = csr_pwdata[MvWidth-1:0];
            REG_SAG_TIMEOUT_MS: cfg_in.sag_timeout_ms = csr_pwdata[TimeWidth-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_DIVIDER_GAIN:   csr_prdata = CsrDataWidth'(cfg_ff.divider_gain);
         REG_DISCONNECT_MV:  csr_prdata = CsrDataWidth'(cfg_ff.disconnect_mv);
         REG_CUTOFF_MV:      csr_prdata = CsrDataWidth'(cfg_ff.cutoff_mv);
         REG_SAG_TIMEOUT_MS: csr_prdata = CsrDataWidth'(cfg_ff.sag_timeout_ms);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.divider_gain   <= GainReset;
         cfg_ff.disconnect_mv  <= DisconnectReset;
         cfg_ff.cutoff_mv      <= CutoffReset;
         cfg_ff.sag_timeout_ms <= TimeoutReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/bum_scale.sv
module bum_scale (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bum_pkg::GainWidth-1:0] divider_gain,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  bum_pkg::func_type             in_func,
   input  logic [bum_pkg::AdcWidth-1:0]  in_adc,
   input  logic [bum_pkg::TimeWidth-1:0] in_now,
   output logic                          out_valid,
   input  logic                          out_ready,
   output bum_pkg::scaled_type           out_item
);
   import bum_pkg::*;

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   func_type             s1_func_ff;
   logic [AdcWidth-1:0]  s1_adc_ff;
   logic [TimeWidth-1:0] s1_now_ff;

   logic                 s2_valid_ff;
   logic                 s2_valid_in;
   scaled_type           s2_item_ff;
   scaled_type           s2_item_in;

   logic                 s1_ready;
   logic                 s2_ready;
   logic [ProdWidth-1:0] prod;
   logic [ProdWidth:0]   prod_rnd;

   assign s2_ready = ~s2_valid_ff | out_ready;
   assign s1_ready = ~s1_valid_ff | s2_ready;
   assign in_ready = s1_ready;

   // round half up into Q.8 millivolts
   assign prod     = ProdWidth'(s1_adc_ff) * ProdWidth'(divider_gain);
   assign prod_rnd = {1'b0, prod} + (ProdWidth + 1)'(1 << (FracBits - 1));

   always_comb begin
      s2_item_in.func   = s1_func_ff;
      s2_item_in.cur    = prod_rnd[FracBits +: LevelWidth];
      s2_item_in.now_ms = s1_now_ff;
   end

   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s1_ready) begin
         s1_func_ff <= in_func;
         s1_adc_ff  <= in_adc;
         s1_now_ff  <= in_now;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_item_ff <= s2_item_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_item  = s2_item_ff;

endmodule

FILE: hw/rtl/bum_filter.sv
module bum_filter (
   input  logic                         clock,
   input  logic                         reset,
   input  bum_pkg::cfg_type             cfg,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  bum_pkg::scaled_type          in_item,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [bum_pkg::MvWidth-1:0]  out_voltage_mv,
   output logic                         out_battery_low,
   output logic                         out_sensor_connected
);
   import bum_pkg::*;

   localparam int unsigned AccWidth   = LevelWidth + 5;   // holds 20 * 2^24
   localparam int unsigned QuarWidth  = AccWidth - 2;
   localparam int unsigned MagicShift = 34;
   localparam logic [31:0] Div5Magic  = 32'hCCCC_CCCD;  // ceil(2^34 / 5)
   localparam int unsigned RecipWidth = QuarWidth + 32;

   logic [LevelWidth-1:0] level_ff, level_in;
   logic [TimeWidth-1:0]  sag_start_ff, sag_start_in;
   logic                  sag_armed_ff, sag_armed_in;
   logic                  low_ff, low_in;

   logic                  out_valid_ff, out_valid_in;
   logic [MvWidth-1:0]    mv_ff;
   logic                  low_out_ff;
   logic                  conn_ff;

   logic                  fire;
   logic [AccWidth-1:0]   acc;
   logic [QuarWidth-1:0]  quarter;
   logic [RecipWidth-1:0] recip;
   logic [LevelWidth-1:0] ema;
   logic [LevelWidth-1:0] disc_q8;
   logic [LevelWidth-1:0] cut_q8;
   logic [TimeWidth-1:0]  elapsed;

   assign in_ready = ~out_valid_ff | out_ready;
   assign fire     = in_valid & in_ready;

   // (19 * level + cur + 10) / 20, as /4 then /5 by reciprocal multiply
   assign acc     = (AccWidth'(level_ff) << 4) + (AccWidth'(level_ff) << 1)
                  + AccWidth'(level_ff) + AccWidth'(in_item.cur) + AccWidth'(10);
   assign quarter = acc[AccWidth-1:2];
   assign recip   = RecipWidth'(quarter) * RecipWidth'(Div5Magic);
   assign ema     = recip[MagicShift +: LevelWidth];

   assign disc_q8 = {cfg.disconnect_mv, FracBits'(0)};
   assign cut_q8  = {cfg.cutoff_mv, FracBits'(0)};
   assign elapsed = in_item.now_ms - sag_start_ff;

   always_comb begin
      level_in     = level_ff;
      sag_start_in = sag_start_ff;
      sag_armed_in = sag_armed_ff;
      low_in       = low_ff;
      if (fire) begin
         if (in_item.func == FUNC_PRIME) begin
            level_in = in_item.cur;
         end else begin
            level_in = ema;
            if (ema < disc_q8) begin
               sag_armed_in = 1'b0;
               sag_start_in = '0;
               low_in       = 1'b0;
            end else if (ema < cut_q8) begin
               if (!sag_armed_ff) begin
                  sag_armed_in = 1'b1;
                  sag_start_in = in_item.now_ms;
               end else if (elapsed > cfg.sag_timeout_ms) begin
                  low_in = 1'b1;
               end
            end else begin
               sag_armed_in = 1'b0;
               sag_start_in = '0;
            end
         end
      end
   end

   assign out_valid_in = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= LevelReset;
         sag_start_ff <= '0;
         sag_armed_ff <= 1'b0;
         low_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         sag_start_ff <= sag_start_in;
         sag_armed_ff <= sag_armed_in;
         low_ff       <= low_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // level is 24 bits, so whole millivolts never exceed 16 bits
   always_ff @(posedge clock) begin
      if (fire) begin
         mv_ff      <= level_in[LevelWidth-1:FracBits];
         low_out_ff <= low_in;
         conn_ff    <= (level_in >= disc_q8);
      end
   end

   assign out_valid            = out_valid_ff;
   assign out_voltage_mv       = mv_ff;
   assign out_battery_low      = low_out_ff;
   assign out_sensor_connected = conn_ff;

endmodule

FILE: hw/rtl/battery_undervoltage_monitor.sv
// Battery undervoltage monitor. Each request transaction carries a raw 12-bit
// ADC reading and a millisecond timestamp; it is scaled to Q.8 millivolts,
// then either primes the filter or runs the 19/20 moving average and the
// disconnect / sag-timer / low-flag check, and gives one response. Throughput
// is one transaction per clock while rsp_tready does not hold the pipeline; a
// result passes through the input register (loaded on the accepting edge), the
// scaling multiply register and then the filter result register. The filter
// state update is combinational between those registers, which sets the clock
// limit: a 27x32 constant multiply for the divide by twenty plus the threshold
// compares. Registers are to be written by the user over the APB port only
// while no transaction is in flight; the block itself does not enforce this.
module battery_undervoltage_monitor (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bum_pkg::ReqDataWidth-1:0]    req_tdata,  // adc_sample[11:0], now_ms[43:12]
   input  logic                                req_tuser,  // func
   // response
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bum_pkg::RspDataWidth-1:0]    rsp_tdata,  // voltage_mv[15:0], battery_low[16],
                                                           // sensor_connected[17]
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bum_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [bum_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [bum_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import bum_pkg::*;

   cfg_type              cfg;
   scaled_type           scaled;
   logic                 scaled_valid;
   logic                 scaled_ready;
   logic [MvWidth-1:0]   voltage_mv;
   logic                 battery_low;
   logic                 sensor_connected;

   bum_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bum_scale u_scale (
      .clock        (clock),
      .reset        (reset),
      .divider_gain (cfg.divider_gain),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_func      (func_type'(req_tuser)),
      .in_adc       (req_tdata[AdcWidth-1:0]),
      .in_now       (req_tdata[AdcWidth +: TimeWidth]),
      .out_valid    (scaled_valid),
      .out_ready    (scaled_ready),
      .out_item     (scaled)
   );

   bum_filter u_filter (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .in_valid             (scaled_valid),
      .in_ready             (scaled_ready),
      .in_item              (scaled),
      .out_valid            (rsp_tvalid),
      .out_ready            (rsp_tready),
      .out_voltage_mv       (voltage_mv),
      .out_battery_low      (battery_low),
      .out_sensor_connected (sensor_connected)
   );

   assign rsp_tdata = {(RspDataWidth - MvWidth - 2)'(0), sensor_connected, battery_low,
                       voltage_mv};

endmodule
